// ----- rtl/core/fdtd_pkg.sv -----
// Shared types, constants and helpers for the 1-D Yee field engine.
`default_nettype none

package fdtd_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_NODES  = 1024;
    localparam int NODE_BITS  = $clog2(MAX_NODES);
    localparam int NUM_FIELDS = 12;
    localparam int SUM_BITS   = VALUE_BITS + 12;

    localparam logic [2:0] CMD_WRITE   = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_AMPERE  = 3'd2;
    localparam logic [2:0] CMD_FARADAY = 3'd3;
    localparam logic [2:0] CMD_SAVE    = 3'd4;
    localparam logic [2:0] CMD_CENTRE  = 3'd5;
    localparam logic [2:0] CMD_CLEAR_J = 3'd6;

    // first array of each group of three components
    localparam logic [3:0] FLD_E  = 4'd0;
    localparam logic [3:0] FLD_B  = 4'd3;
    localparam logic [3:0] FLD_BM = 4'd6;
    localparam logic [3:0] FLD_J  = 4'd9;

    localparam logic [1:0] REG_NUM_PRIMAL = 2'd0;
    localparam logic [1:0] REG_TIME_STEP  = 2'd1;
    localparam logic [1:0] REG_COURANT    = 2'd2;

    localparam logic [9:0]  NUM_PRIMAL_RST = 10'd1023;
    localparam logic [23:0] TIME_STEP_RST  = 24'd62259;
    localparam logic [16:0] COURANT_RST    = 17'd62259;

    typedef struct packed {
        logic [2:0]         command;
        logic [3:0]         field_select;
        logic [9:0]         node_index;
        logic signed [31:0] write_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [2:0]         done_command;
    } out_item_t;

    typedef struct packed {
        logic                         sweep_v;
        logic                         clear_all;
        logic                         cpu_wr;
        logic [NODE_BITS-1:0]         addr;
        logic [2:0]                   cmd;
        logic [3:0]                   sel;
        logic signed [VALUE_BITS-1:0] wdata;
        logic [NODE_BITS-1:0]         np;
    } ctl_t;

    typedef struct packed {
        logic pipe_busy;
    } sts_t;

    function automatic logic signed [VALUE_BITS-1:0] sat_val(
        input logic signed [SUM_BITS-1:0] x
    );
        logic signed [SUM_BITS-1:0] hi;
        logic signed [SUM_BITS-1:0] lo;
        hi = SUM_BITS'({1'b0, {(VALUE_BITS-1){1'b1}}});
        lo = -hi - SUM_BITS'(1);
        if (x > hi)
        begin
            return hi[VALUE_BITS-1:0];
        end
        if (x < lo)
        begin
            return lo[VALUE_BITS-1:0];
        end
        return x[VALUE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fdtd_dp.sv -----
// Datapath: node memories, sweep pipeline and write-back selection.
`default_nettype none

module fdtd_dp
    import fdtd_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ctl_t                         ctl,
    input  wire logic [23:0]                  time_step,
    input  wire logic [16:0]                  courant_ratio,
    output sts_t                              sts,
    output logic signed [VALUE_BITS-1:0]      rd_sel_value
);

    logic signed [VALUE_BITS-1:0] rd_val [NUM_FIELDS];
    logic [NUM_FIELDS-1:0]        we;
    logic [NODE_BITS-1:0]         waddr [NUM_FIELDS];
    logic signed [VALUE_BITS-1:0] wdat [NUM_FIELDS];

    for (genvar f = 0; f < NUM_FIELDS; f++)
    begin : g_mem
        logic signed [VALUE_BITS-1:0] mem [MAX_NODES];
        logic signed [VALUE_BITS-1:0] rd_reg;
        always_ff @(posedge clk)
        begin
            if (we[f])
            begin
                mem[waddr[f]] <= wdat[f];
            end
            rd_reg <= mem[ctl.addr];
        end
        assign rd_val[f] = rd_reg;
    end

    // read stage
    logic                         rd_v_reg;
    logic [NODE_BITS-1:0]         rd_k_reg;
    logic signed [VALUE_BITS-1:0] prv_ey_reg, prv_ez_reg, prv_by_reg, prv_bz_reg;
    logic signed [VALUE_BITS-1:0] prv_jy_reg, prv_jz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= ctl.sweep_v;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_k_reg <= ctl.addr;
        if (rd_v_reg)
        begin
            prv_ey_reg <= rd_val[1];
            prv_ez_reg <= rd_val[2];
            prv_by_reg <= rd_val[4];
            prv_bz_reg <= rd_val[5];
            prv_jy_reg <= rd_val[10];
            prv_jz_reg <= rd_val[11];
        end
    end

    // stage 1: operand selection, differences, averages
    logic signed [VALUE_BITS-1:0] base_next [3];
    logic signed [VALUE_BITS:0]   dif_next [3];
    logic signed [VALUE_BITS-1:0] j_next [3];
    logic [2:0]                   en_next;
    logic [2:0]                   neg_next;
    logic                         k_nz, k_lt;

    assign k_nz = (rd_k_reg != '0);
    assign k_lt = (rd_k_reg < ctl.np);

    always_comb
    begin
        logic signed [VALUE_BITS:0] s;
        for (int l = 0; l < 3; l++)
        begin
            base_next[l] = '0;
            dif_next[l]  = '0;
            j_next[l]    = '0;
        end
        en_next  = '0;
        neg_next = '0;
        s        = '0;
        case (ctl.cmd)
            CMD_AMPERE:
            begin
                base_next[0] = rd_val[0];
                j_next[0]    = rd_val[9];
                base_next[1] = prv_ey_reg;
                dif_next[1]  = {rd_val[5][VALUE_BITS-1], rd_val[5]}
                             - {prv_bz_reg[VALUE_BITS-1], prv_bz_reg};
                j_next[1]    = prv_jy_reg;
                base_next[2] = prv_ez_reg;
                dif_next[2]  = {rd_val[4][VALUE_BITS-1], rd_val[4]}
                             - {prv_by_reg[VALUE_BITS-1], prv_by_reg};
                j_next[2]    = prv_jz_reg;
                neg_next     = 3'b010;
                en_next      = {k_nz, k_nz, 1'b1};
            end
            CMD_FARADAY:
            begin
                base_next[1] = rd_val[4];
                dif_next[1]  = {rd_val[2][VALUE_BITS-1], rd_val[2]}
                             - {prv_ez_reg[VALUE_BITS-1], prv_ez_reg};
                base_next[2] = rd_val[5];
                dif_next[2]  = {rd_val[1][VALUE_BITS-1], rd_val[1]}
                             - {prv_ey_reg[VALUE_BITS-1], prv_ey_reg};
                neg_next     = 3'b100;
                en_next      = {k_nz && k_lt, k_nz && k_lt, 1'b0};
            end
            CMD_SAVE:
            begin
                base_next[0] = rd_val[3];
                base_next[1] = rd_val[4];
                base_next[2] = rd_val[5];
                en_next      = {1'b1, 1'b1, k_lt};
            end
            CMD_CENTRE:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    s = {rd_val[3+l][VALUE_BITS-1], rd_val[3+l]}
                      + {rd_val[6+l][VALUE_BITS-1], rd_val[6+l]};
                    base_next[l] = s[VALUE_BITS:1];
                end
                en_next = {1'b1, 1'b1, k_lt};
            end
            CMD_CLEAR_J:
            begin
                en_next = {k_lt, k_lt, 1'b1};
            end
            default:
            begin
                en_next = '0;
            end
        endcase
    end

    logic                         s1_v_reg;
    logic [NODE_BITS-1:0]         s1_k_reg;
    logic [2:0]                   s1_en_reg, s1_neg_reg;
    logic signed [VALUE_BITS-1:0] s1_base_reg [3];
    logic signed [VALUE_BITS:0]   s1_dif_reg [3];
    logic signed [VALUE_BITS-1:0] s1_j_reg [3];

    // stage 2: products
    logic signed [VALUE_BITS+18:0] pc_full [3];
    logic signed [VALUE_BITS+24:0] pj_full [3];

    for (genvar l = 0; l < 3; l++)
    begin : g_mul
        assign pc_full[l] = s1_dif_reg[l] * $signed({1'b0, courant_ratio});
        assign pj_full[l] = s1_j_reg[l] * $signed({1'b0, time_step});
    end

    logic                         s2_v_reg;
    logic [NODE_BITS-1:0]         s2_k_reg;
    logic [2:0]                   s2_en_reg, s2_neg_reg;
    logic signed [VALUE_BITS-1:0] s2_base_reg [3];
    logic signed [VALUE_BITS+2:0] s2_pc_reg [3];
    logic signed [VALUE_BITS+8:0] s2_pj_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= rd_v_reg;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_k_reg   <= rd_k_reg;
        s1_en_reg  <= en_next;
        s1_neg_reg <= neg_next;
        s2_k_reg   <= s1_k_reg;
        s2_en_reg  <= s1_en_reg;
        s2_neg_reg <= s1_neg_reg;
        for (int l = 0; l < 3; l++)
        begin
            s1_base_reg[l] <= base_next[l];
            s1_dif_reg[l]  <= dif_next[l];
            s1_j_reg[l]    <= j_next[l];
            s2_base_reg[l] <= s1_base_reg[l];
            s2_pc_reg[l]   <= pc_full[l][VALUE_BITS+18:16];
            s2_pj_reg[l]   <= pj_full[l][VALUE_BITS+24:16];
        end
    end

    // stage 3: sum, saturate, write back
    logic signed [VALUE_BITS-1:0] wval [3];

    always_comb
    begin
        logic signed [SUM_BITS-1:0] pc;
        logic signed [SUM_BITS-1:0] sum;
        pc  = '0;
        sum = '0;
        for (int l = 0; l < 3; l++)
        begin
            pc      = SUM_BITS'(s2_pc_reg[l]);
            sum     = SUM_BITS'(s2_base_reg[l]) + (s2_neg_reg[l] ? -pc : pc)
                    - SUM_BITS'(s2_pj_reg[l]);
            wval[l] = sat_val(sum);
        end
    end

    always_comb
    begin
        logic [3:0] grp;
        logic [3:0] idx;
        grp = FLD_E;
        idx = '0;
        for (int f = 0; f < NUM_FIELDS; f++)
        begin
            we[f]    = 1'b0;
            waddr[f] = ctl.addr;
            wdat[f]  = '0;
        end
        if (ctl.clear_all)
        begin
            we = '1;
        end
        else if (ctl.cpu_wr)
        begin
            if (ctl.sel < 4'(NUM_FIELDS))
            begin
                we[ctl.sel]   = 1'b1;
                wdat[ctl.sel] = ctl.wdata;
            end
        end
        else if (s2_v_reg)
        begin
            case (ctl.cmd)
                CMD_AMPERE:            grp = FLD_E;
                CMD_FARADAY:           grp = FLD_B;
                CMD_SAVE, CMD_CENTRE:  grp = FLD_BM;
                default:               grp = FLD_J;
            endcase
            for (int l = 0; l < 3; l++)
            begin
                idx = grp + 4'(l);
                if (s2_en_reg[l])
                begin
                    we[idx]    = 1'b1;
                    wdat[idx]  = wval[l];
                    waddr[idx] = (l != 0 && ctl.cmd == CMD_AMPERE) ?
                                 s2_k_reg - NODE_BITS'(1) : s2_k_reg;
                end
            end
        end
    end

    assign sts.pipe_busy = rd_v_reg | s1_v_reg | s2_v_reg;
    assign rd_sel_value  = (ctl.sel < 4'(NUM_FIELDS)) ? rd_val[ctl.sel] : '0;

endmodule

`default_nettype wire

// ----- rtl/core/fdtd_ctrl.sv -----
// Controller: command sequencing, sweep counter and post-reset clearing pass.
`default_nettype none

module fdtd_ctrl
    import fdtd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire in_item_t             in_data,
    input  wire logic [NODE_BITS-1:0] np,
    input  wire sts_t                 sts,
    input  wire logic                 out_free,
    output logic                      in_ready,
    output logic                      done,
    output ctl_t                      ctl
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                   state_reg, state_next;
    logic [NODE_BITS-1:0]         cnt_reg, cnt_next;
    logic [2:0]                   cmd_reg;
    logic [3:0]                   sel_reg;
    logic [NODE_BITS-1:0]         node_reg;
    logic signed [VALUE_BITS-1:0] wval_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done       = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + NODE_BITS'(1);
                if (cnt_reg == NODE_BITS'(MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    case (in_data.command) inside
                        CMD_AMPERE, CMD_FARADAY, CMD_SAVE, CMD_CENTRE, CMD_CLEAR_J:
                            state_next = S_RUN;
                        default:
                            state_next = S_EXEC;
                    endcase
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
            end
            S_RUN:
            begin
                cnt_next = cnt_reg + NODE_BITS'(1);
                if (cnt_reg == np)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            cmd_reg  <= in_data.command;
            sel_reg  <= in_data.field_select;
            node_reg <= in_data.node_index;
            wval_reg <= in_data.write_value;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign ctl.sweep_v   = (state_reg == S_RUN);
    assign ctl.clear_all = (state_reg == S_CLEAR);
    assign ctl.cpu_wr    = (state_reg == S_EXEC) && (cmd_reg == CMD_WRITE);
    assign ctl.addr      = (state_reg == S_RUN || state_reg == S_CLEAR) ? cnt_reg : node_reg;
    assign ctl.cmd       = cmd_reg;
    assign ctl.sel       = sel_reg;
    assign ctl.wdata     = wval_reg;
    assign ctl.np        = np;

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && cnt_reg == np) |=> state_reg == S_DRAIN)
        else $error("sweep did not stop at last node");

    a_busy_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        sts.pipe_busy |-> (state_reg == S_RUN || state_reg == S_DRAIN))
        else $error("pipeline active outside a sweep");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_free) |=> state_reg == S_OUT)
        else $error("result dropped while output slot full");

endmodule

`default_nettype wire

// ----- rtl/core/fdtd_1d_yee_field_update.sv -----
// Top level: APB register file, output register, controller and datapath.
// Read/write/unused commands: taken in IDLE, then EXEC and OUT, result registered; one item at a time.
// Sweeps: one node per cycle over nodes 0 to P (arrays update P-1, P or P+1), 4-deep pipeline.
// Memory ports (one write, one read per array) set the one-node-per-cycle pace.
// After reset a clearing pass zeroes all 1024 nodes of all arrays; no input taken then.
// Registers reset to num_primal 1023, time_step 62259, courant_ratio 62259.
`default_nettype none

module fdtd_1d_yee_field_update
    import fdtd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [9:0]  np_reg;
    logic [23:0] dt_reg;
    logic [16:0] cr_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;

    ctl_t                         ctl;
    sts_t                         sts;
    logic                         done;
    logic signed [VALUE_BITS-1:0] rd_sel_value;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            np_reg <= NUM_PRIMAL_RST;
            dt_reg <= TIME_STEP_RST;
            cr_reg <= COURANT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_NUM_PRIMAL: np_reg <= pwdata[9:0];
                REG_TIME_STEP:  dt_reg <= pwdata[23:0];
                REG_COURANT:    cr_reg <= pwdata[16:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_NUM_PRIMAL: prdata = 32'(np_reg);
            REG_TIME_STEP:  prdata = 32'(dt_reg);
            REG_COURANT:    prdata = 32'(cr_reg);
            default:        prdata = '0;
        endcase
    end

    fdtd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_data  (in_data),
        .np       (np_reg),
        .sts      (sts),
        .out_free (!out_valid_reg || out_ready),
        .in_ready (in_ready),
        .done     (done),
        .ctl      (ctl)
    );

    fdtd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .time_step     (dt_reg),
        .courant_ratio (cr_reg),
        .sts           (sts),
        .rd_sel_value  (rd_sel_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_data_reg.read_value   <= (ctl.cmd == CMD_READ) ? rd_sel_value : '0;
            out_data_reg.done_command <= ctl.cmd;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- sim/tb_fdtd_1d_yee_field_update.sv -----
// Testbench for the 1-D Yee field engine: field predictor, result checker, APB config.
`default_nettype none

module tb_fdtd_1d_yee_field_update;
    import fdtd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fdtd_1d_yee_field_update dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 clk = ~clk;

    // predictor state: index [component][node]
    longint e_fld [3][MAX_NODES];
    longint b_fld [3][MAX_NODES];
    longint bm_fld[3][MAX_NODES];
    longint j_fld [3][MAX_NODES];
    int unsigned grid_p;
    int unsigned dt_q;
    int unsigned cr_q;

    out_item_t result_q[$];
    int  fail_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  recv_hold = 1'b0;
    int  idle_cycles = 0;

    function automatic longint clamp32(longint x);
        if (x > VMAX) return VMAX;
        if (x < VMIN) return VMIN;
        return x;
    endfunction

    function automatic longint mulq(longint a, int unsigned k);
        return (a * longint'(k)) >>> 16;
    endfunction

    function automatic longint avg_down(longint a, longint b);
        return (a + b) >>> 1;
    endfunction

    task automatic predict_item(input in_item_t it);
        out_item_t r;
        int unsigned np, nd, c, n, sel;
        longint ey, ez;
        r = '0;
        r.done_command = it.command;
        np = grid_p;
        nd = np + 1;
        sel = it.field_select;
        n = it.node_index;
        case (it.command)
            CMD_WRITE:
                if (sel < NUM_FIELDS)
                begin
                    c = sel % 3;
                    if (sel < FLD_B) e_fld[c][n] = it.write_value;
                    else if (sel < FLD_BM) b_fld[c][n] = it.write_value;
                    else if (sel < FLD_J) bm_fld[c][n] = it.write_value;
                    else j_fld[c][n] = it.write_value;
                end
            CMD_READ:
                if (sel < NUM_FIELDS)
                begin
                    c = sel % 3;
                    if (sel < FLD_B) r.read_value = 32'(e_fld[c][n]);
                    else if (sel < FLD_BM) r.read_value = 32'(b_fld[c][n]);
                    else if (sel < FLD_J) r.read_value = 32'(bm_fld[c][n]);
                    else r.read_value = 32'(j_fld[c][n]);
                end
            CMD_AMPERE:
            begin
                for (int i = 0; i < nd; i++)
                    e_fld[0][i] = clamp32(e_fld[0][i] - mulq(j_fld[0][i], dt_q));
                for (int i = 0; i < np; i++)
                begin
                    ey = e_fld[1][i] - mulq(b_fld[2][i+1] - b_fld[2][i], cr_q)
                         - mulq(j_fld[1][i], dt_q);
                    ez = e_fld[2][i] + mulq(b_fld[1][i+1] - b_fld[1][i], cr_q)
                         - mulq(j_fld[2][i], dt_q);
                    e_fld[1][i] = clamp32(ey);
                    e_fld[2][i] = clamp32(ez);
                end
            end
            CMD_FARADAY:
                for (int i = 1; i + 1 < nd; i++)
                begin
                    b_fld[1][i] = clamp32(b_fld[1][i] + mulq(e_fld[2][i] - e_fld[2][i-1], cr_q));
                    b_fld[2][i] = clamp32(b_fld[2][i] - mulq(e_fld[1][i] - e_fld[1][i-1], cr_q));
                end
            CMD_SAVE:
            begin
                for (int i = 0; i < np; i++) bm_fld[0][i] = b_fld[0][i];
                for (int k = 1; k < 3; k++)
                    for (int i = 0; i < nd; i++) bm_fld[k][i] = b_fld[k][i];
            end
            CMD_CENTRE:
            begin
                for (int i = 0; i < np; i++) bm_fld[0][i] = avg_down(b_fld[0][i], bm_fld[0][i]);
                for (int k = 1; k < 3; k++)
                    for (int i = 0; i < nd; i++)
                        bm_fld[k][i] = avg_down(b_fld[k][i], bm_fld[k][i]);
            end
            CMD_CLEAR_J:
            begin
                for (int i = 0; i < nd; i++) j_fld[0][i] = 0;
                for (int i = 0; i < np; i++)
                begin
                    j_fld[1][i] = 0;
                    j_fld[2][i] = 0;
                end
            end
            default: ;
        endcase
        result_q.push_back(r);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_NUM_PRIMAL: grid_p = val[9:0];
            REG_TIME_STEP:  dt_q = val[23:0];
            default:        cr_q = val[16:0];
        endcase
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (result_q.size() != 0) @(negedge clk);
        repeat (1100) @(negedge clk);
    endtask

    task automatic configure(input int unsigned p, input int unsigned dt, input int unsigned cr);
        drain();
        apb_write(REG_NUM_PRIMAL, p);
        apb_write(REG_TIME_STEP, dt);
        apb_write(REG_COURANT, cr);
    endtask

    // valid stays up after a transfer until the next item or drain replaces it
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_item(it);
        @(negedge clk);
    endtask

    function automatic in_item_t make_item(input logic [2:0] cmd, input logic [3:0] sel,
                                           input logic [9:0] n, input logic [31:0] v);
        in_item_t it;
        it.command = cmd; it.field_select = sel; it.node_index = n; it.write_value = v;
        return it;
    endfunction

    function automatic logic [31:0] rand_value;
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(255) << 16;
            3: return -($urandom_range(255) << 16);
            default: return $urandom;
        endcase
    endfunction

    always @(negedge clk)
        out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
        begin
            if (result_q.size() == 0)
            begin
                $error("unexpected transfer: read_value %h done_command %0d",
                       out_data.read_value, out_data.done_command);
                fail_count++;
            end
            else
            begin
                out_item_t exp_r;
                exp_r = result_q.pop_front();
                if (out_data.read_value !== exp_r.read_value)
                begin
                    $error("read_value expected %h actual %h", exp_r.read_value,
                           out_data.read_value);
                    fail_count++;
                end
                if (out_data.done_command !== exp_r.done_command)
                begin
                    $error("done_command expected %0d actual %0d", exp_r.done_command,
                           out_data.done_command);
                    fail_count++;
                end
            end
        end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || recv_hold)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_directed;
        send_item(make_item(CMD_READ, FLD_E, 10'd5, 32'h0));
        send_item(make_item(CMD_WRITE, 4'(FLD_B + 2), 10'd1, 32'h7fffffff));
        send_item(make_item(CMD_WRITE, 4'(FLD_B + 2), 10'd2, 32'h80000000));
        send_item(make_item(CMD_WRITE, 4'(FLD_B + 1), 10'd1, 32'h00010000));
        send_item(make_item(CMD_WRITE, FLD_J, 10'd0, 32'h80000000));
        send_item(make_item(CMD_WRITE, 4'(FLD_J + 1), 10'd1, 32'h7fffffff));
        send_item(make_item(CMD_WRITE, 4'(FLD_E + 1), 10'd1023, 32'hdeadbeef));
        send_item(make_item(CMD_WRITE, 4'd15, 10'd3, 32'h12345678));
        send_item(make_item(CMD_READ, 4'd12, 10'd3, 32'hffffffff));
        send_item(make_item(CMD_READ, 4'(FLD_E + 1), 10'd1023, 32'h0));
        send_item(make_item(CMD_AMPERE, 4'd0, 10'd0, 32'h0));
        send_item(make_item(CMD_FARADAY, 4'd0, 10'd0, 32'h0));
        send_item(make_item(CMD_SAVE, 4'd0, 10'd0, 32'h0));
        send_item(make_item(CMD_CENTRE, 4'd0, 10'd0, 32'h0));
        send_item(make_item(CMD_CLEAR_J, 4'd0, 10'd0, 32'h0));
        send_item(make_item(3'd7, 4'd11, 10'd9, 32'hffffffff));
        for (int s = 0; s < NUM_FIELDS; s++)
            send_item(make_item(CMD_READ, 4'(s), 10'd1, 32'h0));
    endtask

    // mostly point writes and reads in the live grid, sweeps now and then
    task automatic test_random(input int count, input int unsigned span);
        logic [2:0] cmd;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4, 5, 6, 7: cmd = CMD_WRITE;
                8, 9, 10, 11, 12, 13: cmd = CMD_READ;
                14: cmd = CMD_AMPERE;
                15: cmd = CMD_FARADAY;
                16: cmd = CMD_SAVE;
                17: cmd = CMD_CENTRE;
                18: cmd = CMD_CLEAR_J;
                default: cmd = 3'($urandom_range(7));
            endcase
            send_item(make_item(cmd,
                ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(11)),
                ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(span)),
                rand_value()));
        end
    endtask

    task automatic test_backpressure;
        recv_hold = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                recv_hold = 1'b0;
            end
            test_random(40, 8);
        join
    endtask

    initial
    begin
        grid_p = NUM_PRIMAL_RST;
        dt_q = TIME_STEP_RST;
        cr_q = COURANT_RST;
        for (int c = 0; c < 3; c++)
            for (int i = 0; i < MAX_NODES; i++)
            begin
                e_fld[c][i] = 0; b_fld[c][i] = 0; bm_fld[c][i] = 0; j_fld[c][i] = 0;
            end
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        configure(8, 24'd65536, 17'd32768);
        send_idle_pct = 7; recv_idle_pct = 59;
        test_directed();
        test_random(150, 10);
        configure(2, 24'hffffff, 17'd65536);
        send_idle_pct = 59; recv_idle_pct = 7;
        test_random(120, 4);
        configure(16, 24'd0, 17'd0);
        test_random(100, 18);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_backpressure();
        configure(1023, 24'd62259, 17'd62259);
        test_random(30, 1023);
        configure(12, 24'd1000, 17'd40000);
        test_random(150, 14);
        drain();
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/fdtd_pkg.sv
rtl/core/fdtd_dp.sv
rtl/core/fdtd_ctrl.sv
rtl/core/fdtd_1d_yee_field_update.sv
sim/tb_fdtd_1d_yee_field_update.sv
